/* hw/rtl/owsm_pkg.sv */
// Package for the omni wheel speed mixer: operation codes, sequencer states,
// the CORDIC arctangent table and shared constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package owsm_pkg;

  localparam int unsigned Wheels = 4;
  localparam int unsigned TrigIterations = 16;
  localparam int unsigned TrigIterW = $clog2(TrigIterations + 1);
  localparam logic signed [39:0] CordicGain = 40'sd652032874;
  localparam logic signed [18:0] FullTurn = 19'sd36000;
  localparam logic signed [18:0] HalfTurn = 19'sd18000;
  localparam logic signed [18:0] QuarterTurn = 19'sd9000;
  localparam logic [15:0] ScaleReset = 16'd822;

  typedef enum logic [1:0] {
    OpLinear = 2'd0,
    OpRotAll = 2'd1,
    OpRotFront = 2'd2,
    OpEmit = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CfgHeadingOffset = 1'b0,
    CfgMotorScale = 1'b1
  } cfg_e;

  typedef enum logic [3:0] {
    StIdle,
    StSquare,
    StSqrt,
    StDivX,
    StDivY,
    StAngle,
    StReduce,
    StCordic,
    StMulCos,
    StMulSin,
    StAddLin,
    StRotAdd,
    StEmitMul,
    StEmitOut
  } state_e;

  function automatic logic [29:0] atan_lookup(input logic [4:0] idx);
    logic [29:0] r;
    begin
      unique case (idx)
        5'd0: r = 30'd294912000;
        5'd1: r = 30'd174096719;
        5'd2: r = 30'd91987925;
        5'd3: r = 30'd46694507;
        5'd4: r = 30'd23437865;
        5'd5: r = 30'd11730358;
        5'd6: r = 30'd5866610;
        5'd7: r = 30'd2933484;
        5'd8: r = 30'd1466765;
        5'd9: r = 30'd733385;
        5'd10: r = 30'd366693;
        5'd11: r = 30'd183347;
        5'd12: r = 30'd91674;
        5'd13: r = 30'd45837;
        5'd14: r = 30'd22918;
        5'd15: r = 30'd11459;
        5'd16: r = 30'd5730;
        5'd17: r = 30'd2865;
        5'd18: r = 30'd1432;
        5'd19: r = 30'd716;
        5'd20: r = 30'd358;
        5'd21: r = 30'd179;
        5'd22: r = 30'd90;
        5'd23: r = 30'd45;
        default: r = 30'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [18:0] wheel_offset(input logic [1:0] k);
    logic signed [18:0] r;
    begin
      unique case (k)
        2'd0: r = -19'sd13500;
        2'd1: r = -19'sd4500;
        2'd2: r = 19'sd4500;
        default: r = 19'sd13500;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/omni_wheel_speed_mixer_unit.sv */
// Omni wheel speed mixer top level: sequencer, shared divider/sqrt unit,
// CORDIC and one shared multiplier. Depends on owsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
//  Channel  | Direction | Handshake          | Payload
//  s_axis   | in        | tvalid/tready      | tdata: op, dir_x, dir_y, heading, speed
//  m_axis   | out       | tvalid/tready      | tdata: wheel0..wheel3 commands
//  cfg      | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// A linear move runs the sum of squares of x and y, a 16-step square root, two
// 32-step restoring divisions, and per wheel the angle, a 16-step CORDIC and
// two products through one multiplier. Reset clears the accumulators and loads
// the register defaults. Input is accepted only in the idle state and only while
// no result waits in the output register, so a stalled output stalls the input.
module omni_wheel_speed_mixer_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata bits from 0: operation[1:0], dir_x[17:2], dir_y[33:18],
  // heading[50:34], speed[66:51], zero fill to 72 bits
  input  wire  [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata bits from 0: wheel0_cmd, wheel1_cmd, wheel2_cmd, wheel3_cmd
  output logic [127:0] m_axis_tdata,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [15:0] cfg_data_i
);

  owsm_pkg::state_e state_q, state_d;

  logic signed [15:0] hoff_q;
  logic [15:0] scale_q;
  logic signed [31:0] acc_q [owsm_pkg::Wheels];

  logic [1:0] op_q;
  logic signed [15:0] x_q, y_q, sp_q;
  logic signed [16:0] hd_q;

  // Shared iteration counter and wheel index.
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] wk_q, wk_d;

  // Square root / divider working registers.
  logic [31:0] rem_q, rem_d;   // sqrt remainder
  logic [31:0] sq_q, sq_d;     // sqrt input shifted out two bits per step
  logic [16:0] root_q, root_d;
  logic [31:0] dnum_q, dnum_d; // magnitude of dividend
  logic [32:0] drem_q, drem_d;
  logic [31:0] dq_q, dq_d;
  logic dneg_q, dneg_d;
  logic signed [31:0] vx_q, vx_d, vy_q, vy_d;

  // CORDIC.
  logic signed [39:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic neg_q, neg_d;
  logic signed [18:0] ang_q, ang_d;
  logic signed [15:0] sin_q, sin_d, cos_q, cos_d;

  // Shared multiplier result and product sum registers.
  logic signed [48:0] prod_q, prod_d, psum_q, psum_d;

  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] mul_p;
  assign mul_p = 49'(mul_a) * 49'(mul_b);

  logic out_v_q;
  logic [127:0] out_q;
  logic [127:0] out_d;
  logic acc_we;
  logic signed [31:0] acc_wd;
  logic [1:0] acc_wi;
  logic acc_clr;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [39:0] v);
    logic signed [39:0] r;
    begin
      r = (v + 40'sd16384) >>> 15;
      if (r > 40'sd32767) return 16'sd32767;
      if (r < -40'sd32768) return -16'sd32768;
      return r[15:0];
    end
  endfunction

  // Square root step candidate and divider step.
  logic [33:0] sq_trial_rem;
  logic [33:0] sq_trial;
  logic [32:0] dv_sh;
  logic [32:0] dv_sub;
  assign sq_trial_rem = {rem_q, sq_q[31:30]};
  assign sq_trial = {15'd0, root_q, 2'b01};
  assign dv_sh = {drem_q[31:0], dnum_q[31]};
  assign dv_sub = dv_sh - {16'd0, root_q};

  logic signed [39:0] ysh, xsh;
  assign ysh = cy_q >>> cnt_q[4:0];
  assign xsh = cx_q >>> cnt_q[4:0];

  logic signed [18:0] ang_red;
  always_comb begin
    ang_red = ang_q;
    if (ang_red < 19'sd0) ang_red = ang_red + owsm_pkg::FullTurn;
    if (ang_red > owsm_pkg::HalfTurn) ang_red = ang_red - owsm_pkg::FullTurn;
  end

  assign s_axis_tready = (state_q == owsm_pkg::StIdle) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      owsm_pkg::StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          unique case (owsm_pkg::op_e'(s_axis_tdata[1:0]))
            owsm_pkg::OpLinear: state_d = owsm_pkg::StSquare;
            owsm_pkg::OpEmit: state_d = owsm_pkg::StEmitMul;
            default: state_d = owsm_pkg::StRotAdd;
          endcase
        end
      end
      owsm_pkg::StSquare: if (cnt_q == 6'd1) state_d = owsm_pkg::StSqrt;
      owsm_pkg::StSqrt: if (cnt_q == 6'd15) state_d = owsm_pkg::StDivX;
      owsm_pkg::StDivX: if (cnt_q == 6'd32) state_d = owsm_pkg::StDivY;
      owsm_pkg::StDivY: if (cnt_q == 6'd32) state_d = owsm_pkg::StAngle;
      owsm_pkg::StAngle: if (cnt_q == 6'd1) state_d = owsm_pkg::StReduce;
      owsm_pkg::StReduce: state_d = owsm_pkg::StCordic;
      owsm_pkg::StCordic:
        if (cnt_q == 6'(owsm_pkg::TrigIterations)) state_d = owsm_pkg::StMulCos;
      owsm_pkg::StMulCos: state_d = owsm_pkg::StMulSin;
      owsm_pkg::StMulSin: state_d = owsm_pkg::StAddLin;
      owsm_pkg::StAddLin:
        state_d = (wk_q == 2'd3) ? owsm_pkg::StIdle : owsm_pkg::StAngle;
      owsm_pkg::StRotAdd:
        if (wk_q == 2'd3 || (op_q == owsm_pkg::OpRotFront && wk_q == 2'd1))
          state_d = owsm_pkg::StIdle;
      owsm_pkg::StEmitMul: state_d = owsm_pkg::StEmitOut;
      owsm_pkg::StEmitOut:
        state_d = (wk_q == 2'd3) ? owsm_pkg::StIdle : owsm_pkg::StEmitMul;
      default: state_d = owsm_pkg::StIdle;
    endcase
  end

  // Datapath control.
  always_comb begin
    cnt_d = cnt_q + 6'd1;
    wk_d = wk_q;
    rem_d = rem_q; sq_d = sq_q; root_d = root_q;
    dnum_d = dnum_q; drem_d = drem_q; dq_d = dq_q; dneg_d = dneg_q;
    vx_d = vx_q; vy_d = vy_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; neg_d = neg_q; ang_d = ang_q;
    sin_d = sin_q; cos_d = cos_q;
    prod_d = prod_q; psum_d = psum_q;
    mul_a = 32'(x_q); mul_b = 17'(x_q);
    acc_we = 1'b0; acc_wd = '0; acc_wi = wk_q; acc_clr = 1'b0;
    out_d = out_q;
    unique case (state_q)
      owsm_pkg::StIdle: begin
        cnt_d = '0; wk_d = '0;
      end
      owsm_pkg::StSquare: begin
        // The multiplier forms x*x, then y*y, and their sum is kept.
        mul_a = (cnt_q == 6'd0) ? 32'(x_q) : 32'(y_q);
        mul_b = (cnt_q == 6'd0) ? 17'(x_q) : 17'(y_q);
        if (cnt_q == 6'd0) prod_d = mul_p;
        else begin
          sq_d = 32'(prod_q) + 32'(mul_p);
          rem_d = '0; root_d = '0; cnt_d = '0;
        end
      end
      owsm_pkg::StSqrt: begin
        // One result bit per cycle, two input bits consumed.
        sq_d = {sq_q[29:0], 2'b00};
        if (sq_trial_rem >= sq_trial) begin
          rem_d = 32'(sq_trial_rem - sq_trial);
          root_d = {root_q[15:0], 1'b1};
        end else begin
          rem_d = sq_trial_rem[31:0];
          root_d = {root_q[15:0], 1'b0};
        end
        if (cnt_q == 6'd15) begin
          // Load the divider with |x*speed|.
          mul_a = 32'(x_q); mul_b = 17'(sp_q);
          dnum_d = mul_p[48] ? 32'(-mul_p) : mul_p[31:0];
          dneg_d = mul_p[48];
          drem_d = '0; dq_d = '0; cnt_d = '0;
        end
      end
      owsm_pkg::StDivX, owsm_pkg::StDivY: begin
        if (cnt_q < 6'd32) begin
          dnum_d = {dnum_q[30:0], 1'b0};
          if (!dv_sub[32]) begin
            drem_d = dv_sub; dq_d = {dq_q[30:0], 1'b1};
          end else begin
            drem_d = dv_sh; dq_d = {dq_q[30:0], 1'b0};
          end
        end else begin
          cnt_d = '0;
          if (state_q == owsm_pkg::StDivX) begin
            vx_d = (root_q == '0) ? '0 : (dneg_q ? -dq_q : dq_q);
            mul_a = 32'(y_q); mul_b = 17'(sp_q);
            dnum_d = mul_p[48] ? 32'(-mul_p) : mul_p[31:0];
            dneg_d = mul_p[48];
            drem_d = '0; dq_d = '0;
          end else begin
            vy_d = (root_q == '0) ? '0 : (dneg_q ? -dq_q : dq_q);
          end
        end
      end
      owsm_pkg::StAngle: begin
        // Sum the angle, then reduce it modulo a full turn.
        if (cnt_q == 6'd0) begin
          ang_d = 19'(hd_q) + 19'(hoff_q) + owsm_pkg::wheel_offset(wk_q);
        end else begin
          if (ang_q >= owsm_pkg::FullTurn) ang_d = ang_q - owsm_pkg::FullTurn;
          else if (ang_q <= -owsm_pkg::FullTurn) ang_d = ang_q + owsm_pkg::FullTurn;
          if (ang_q >= owsm_pkg::FullTurn + owsm_pkg::FullTurn)
            ang_d = ang_q - owsm_pkg::FullTurn - owsm_pkg::FullTurn;
          else if (ang_q <= -owsm_pkg::FullTurn - owsm_pkg::FullTurn)
            ang_d = ang_q + owsm_pkg::FullTurn + owsm_pkg::FullTurn;
        end
      end
      owsm_pkg::StReduce: begin
        cnt_d = '0;
        neg_d = 1'b0;
        if (ang_red > owsm_pkg::QuarterTurn) begin
          cz_d = 40'(ang_red - owsm_pkg::HalfTurn) <<< 16; neg_d = 1'b1;
        end else if (ang_red < -owsm_pkg::QuarterTurn) begin
          cz_d = 40'(ang_red + owsm_pkg::HalfTurn) <<< 16; neg_d = 1'b1;
        end else begin
          cz_d = 40'(ang_red) <<< 16;
        end
        cx_d = owsm_pkg::CordicGain;
        cy_d = '0;
      end
      owsm_pkg::StCordic: begin
        if (cnt_q < 6'(owsm_pkg::TrigIterations)) begin
          if (!cz_q[39]) begin
            cx_d = cx_q - ysh; cy_d = cy_q + xsh;
            cz_d = cz_q - 40'(owsm_pkg::atan_lookup(cnt_q[4:0]));
          end else begin
            cx_d = cx_q + ysh; cy_d = cy_q - xsh;
            cz_d = cz_q + 40'(owsm_pkg::atan_lookup(cnt_q[4:0]));
          end
        end else begin
          cos_d = to_q15(neg_q ? -cx_q : cx_q);
          sin_d = to_q15(neg_q ? -cy_q : cy_q);
        end
      end
      owsm_pkg::StMulCos: begin
        mul_a = vx_q; mul_b = 17'(cos_q);
        prod_d = mul_p;
      end
      owsm_pkg::StMulSin: begin
        mul_a = vy_q; mul_b = 17'(sin_q);
        psum_d = prod_q + mul_p;
      end
      owsm_pkg::StAddLin: begin
        // Division by 32768 truncating toward zero.
        acc_we = 1'b1;
        acc_wd = sat32(50'(acc_q[wk_q]) + 50'(psum_q[48] ?
          -((-psum_q) >>> 15) : (psum_q >>> 15)));
        wk_d = wk_q + 2'd1;
        cnt_d = '0;
      end
      owsm_pkg::StRotAdd: begin
        acc_we = 1'b1;
        acc_wd = sat32(50'(acc_q[wk_q]) + 50'(sp_q));
        wk_d = wk_q + 2'd1;
      end
      owsm_pkg::StEmitMul: begin
        mul_a = acc_q[wk_q]; mul_b = {1'b0, scale_q};
        prod_d = mul_p;
      end
      owsm_pkg::StEmitOut: begin
        out_d[32*wk_q +: 32] = sat32(50'(prod_q[48] ?
          -((-prod_q) >>> 8) : (prod_q >>> 8)));
        acc_we = 1'b1; acc_wd = '0;
        wk_d = wk_q + 2'd1;
        acc_clr = (wk_q == 2'd3);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= owsm_pkg::StIdle;
      hoff_q <= '0;
      scale_q <= owsm_pkg::ScaleReset;
      out_v_q <= 1'b0;
      cnt_q <= '0;
      wk_q <= '0;
      for (int i = 0; i < owsm_pkg::Wheels; i++) acc_q[i] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      wk_q <= wk_d;
      if (cfg_we_i) begin
        if (owsm_pkg::cfg_e'(cfg_idx_i) == owsm_pkg::CfgHeadingOffset) hoff_q <= cfg_data_i;
        else scale_q <= cfg_data_i;
      end
      if (acc_we) acc_q[acc_wi] <= acc_wd;
      if (acc_clr) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q <= s_axis_tdata[1:0];
      x_q <= s_axis_tdata[17:2];
      y_q <= s_axis_tdata[33:18];
      hd_q <= s_axis_tdata[50:34];
      sp_q <= s_axis_tdata[66:51];
    end
    rem_q <= rem_d; sq_q <= sq_d; root_q <= root_d;
    dnum_q <= dnum_d; drem_q <= drem_d; dq_q <= dq_d; dneg_q <= dneg_d;
    vx_q <= vx_d; vy_q <= vy_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; neg_q <= neg_d; ang_q <= ang_d;
    sin_q <= sin_d; cos_q <= cos_d;
    prod_q <= prod_d; psum_q <= psum_d;
    out_q <= out_d;
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != owsm_pkg::StIdle) |-> !s_axis_tready)
    else $error("input accepted while busy");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == owsm_pkg::StEmitOut && wk_q == 2'd3) |=> m_axis_tvalid)
    else $error("emit lost its result");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == owsm_pkg::StCordic) |-> (cnt_q <= 6'(owsm_pkg::TrigIterations)))
    else $error("cordic counter overrun");

endmodule
`default_nettype wire
